FILE: rtl/cbm_pkg.sv
// ----------------------------------------------------------------------------
// cbm_pkg
// Types, codes and reset values shared by the bank mapper files.
// ----------------------------------------------------------------------------
package cbm_pkg;

  localparam int unsigned OpW     = 3;
  localparam int unsigned AddrW   = 16;
  localparam int unsigned DataW   = 8;
  localparam int unsigned KindW   = 3;
  localparam int unsigned OffW    = 13;
  localparam int unsigned CtrW    = 16;
  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned NumPrg  = 3;
  localparam int unsigned NumChr  = 12;

  typedef enum logic [OpW-1:0] {
    OpCpuWrite = 3'd0,
    OpCpuRead  = 3'd1,
    OpTick     = 3'd2,
    OpXlateCpu = 3'd3,
    OpXlatePpu = 3'd4
  } op_e;

  typedef enum logic [KindW-1:0] {
    KindNone      = 3'd0,
    KindPrgRom    = 3'd1,
    KindWorkRam   = 3'd2,
    KindChrRom    = 3'd3,
    KindChrRam    = 3'd4,
    KindNametable = 3'd5
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgChrRam    = 4'd0,
    CfgExtraVram = 4'd1
  } cfg_idx_e;

  localparam logic [3:0]      PageCtr     = 4'h5;
  localparam logic [2:0]      SegWram     = 3'b011;
  localparam logic [2:0]      SegPrgRegs  = 3'b111;
  localparam logic [1:0]      PrgRegProt  = 2'd3;
  localparam logic [1:0]      PrgSlotLast = 2'd3;
  localparam logic [3:0]      ProtUnlock  = 4'h4;
  localparam logic [7:0]      PrgMask     = 8'h3F;
  localparam logic [7:0]      ChrHighBase = 8'hE0;
  localparam logic [5:0]      PpuSlotEnd  = 6'd12;
  localparam logic [CtrW-1:0] CtrTop      = 16'hFFFF;
  localparam logic [CtrW-1:0] CtrLast     = 16'hFFFE;

  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [AddrW-1:0] addr;
    logic [DataW-1:0] wdata;
  } item_t;

  typedef struct packed {
    logic [DataW-1:0] read_data;
    logic             read_handled;
    logic             irq_line;
    logic             wram_ok;
    logic [KindW-1:0] kind;
    logic [7:0]       bank;
    logic [OffW-1:0]  offset;
  } rsp_t;

  typedef struct packed {
    logic              chr_ram;
    logic              extra_vram;
    logic [NumPrg-1:0][7:0] prg;
    logic [NumChr-1:0][7:0] chr;
    logic [7:0]        prot;
    logic [CtrW-1:0]   ctr;
    logic              irq;
  } st_t;

  typedef struct packed {
    logic             chr_we;
    logic [3:0]       chr_idx;
    logic             prg_we;
    logic [1:0]       prg_idx;
    logic             prot_we;
    logic             ctr_lo_we;
    logic             ctr_hi_we;
    logic             ctr_inc;
    logic             irq_set;
    logic             irq_clr;
    logic [DataW-1:0] data;
  } upd_t;

  localparam st_t StRst = '{
    chr_ram:    1'b0,
    extra_vram: 1'b0,
    prg:        {8'hFE, 8'hFD, 8'hFC},
    chr:        {8'hE1, 8'hE0, 8'hE1, 8'hE0, 8'h07, 8'h06,
                 8'h05, 8'h04, 8'h03, 8'h02, 8'h01, 8'h00},
    prot:       8'hFF,
    ctr:        16'h0000,
    irq:        1'b0
  };

endpackage

FILE: rtl/cbm_if.sv
// ----------------------------------------------------------------------------
// cbm_if
// Request, response and configuration channels of the bank mapper.
// ----------------------------------------------------------------------------
interface cbm_req_if import cbm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OpW-1:0]   operation;
  logic [AddrW-1:0] address;
  logic [DataW-1:0] write_data;

  modport source (output valid, output operation, output address, output write_data,
                  input ready);
  modport sink   (input valid, input operation, input address, input write_data,
                  output ready);
endinterface

interface cbm_rsp_if import cbm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DataW-1:0] read_data;
  logic             read_handled;
  logic             irq_line;
  logic             work_ram_write_ok;
  logic [KindW-1:0] target_kind;
  logic [7:0]       target_bank;
  logic [OffW-1:0]  target_offset;

  modport source (output valid, output read_data, output read_handled, output irq_line,
                  output work_ram_write_ok, output target_kind, output target_bank,
                  output target_offset, input ready);
  modport sink   (input valid, input read_data, input read_handled, input irq_line,
                  input work_ram_write_ok, input target_kind, input target_bank,
                  input target_offset, output ready);
endinterface

interface cbm_cfg_if import cbm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [DataW-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/cbm_map.sv
// ----------------------------------------------------------------------------
// cbm_map
// Decodes one request against the current state: result fields and state update.
// ----------------------------------------------------------------------------
module cbm_map import cbm_pkg::*; (
  input  item_t item_i,
  input  st_t   st_i,
  output rsp_t  rsp_o,
  output upd_t  upd_o
);

  logic       wram_ok;
  logic [1:0] prg_slot;
  logic [7:0] prg_bank;
  logic [7:0] chr_val;
  logic       chr_force;

  assign wram_ok = (item_i.addr[15:13] == SegWram) && (st_i.prot[7:4] == ProtUnlock)
                   && !st_i.prot[item_i.addr[12:11]];

  assign prg_slot = item_i.addr[14:13];
  assign prg_bank = (prg_slot == PrgSlotLast) ? PrgMask : (st_i.prg[prg_slot] & PrgMask);

  assign chr_val   = st_i.chr[item_i.addr[13:10]];
  assign chr_force = (item_i.addr[13:12] == 2'b00) ? st_i.prg[1][6] :
                     (item_i.addr[13:12] == 2'b01) ? st_i.prg[1][7] : 1'b0;

  always_comb begin
    rsp_o          = '0;
    upd_o          = '0;
    upd_o.data     = item_i.wdata;
    rsp_o.irq_line = st_i.irq;
    case (item_i.op)
      OpCpuWrite: begin
        rsp_o.wram_ok = wram_ok;
        if (item_i.addr[15:12] == PageCtr) begin
          upd_o.ctr_hi_we = item_i.addr[11];
          upd_o.ctr_lo_we = !item_i.addr[11];
          upd_o.irq_clr   = 1'b1;
          rsp_o.irq_line  = 1'b0;
        end else if (item_i.addr[15:12] inside {[4'h8:4'hD]}) begin
          upd_o.chr_we  = 1'b1;
          upd_o.chr_idx = item_i.addr[14:11];
        end else if (item_i.addr[15:13] == SegPrgRegs) begin
          if (item_i.addr[12:11] == PrgRegProt) begin
            upd_o.prot_we = 1'b1;
          end else begin
            upd_o.prg_we  = 1'b1;
            upd_o.prg_idx = item_i.addr[12:11];
          end
        end
      end
      OpCpuRead: begin
        if (item_i.addr[15:12] == PageCtr) begin
          rsp_o.read_handled = 1'b1;
          rsp_o.read_data    = item_i.addr[11] ? st_i.ctr[15:8] : st_i.ctr[7:0];
        end
      end
      OpTick: begin
        if (st_i.ctr[15] && (st_i.ctr != CtrTop)) begin
          upd_o.ctr_inc = 1'b1;
          if (st_i.ctr == CtrLast) begin
            upd_o.irq_set  = 1'b1;
            rsp_o.irq_line = 1'b1;
          end
        end
      end
      OpXlateCpu: begin
        rsp_o.wram_ok = wram_ok;
        if (item_i.addr[15]) begin
          rsp_o.kind   = KindPrgRom;
          rsp_o.bank   = prg_bank;
          rsp_o.offset = item_i.addr[12:0];
        end else if (item_i.addr[15:13] == SegWram) begin
          rsp_o.kind   = KindWorkRam;
          rsp_o.offset = item_i.addr[12:0];
        end
      end
      OpXlatePpu: begin
        if (item_i.addr[15:10] < PpuSlotEnd) begin
          rsp_o.offset = {3'b000, item_i.addr[9:0]};
          if ((chr_val < ChrHighBase) || chr_force) begin
            rsp_o.kind = KindChrRom;
            rsp_o.bank = chr_val;
          end else if (st_i.chr_ram) begin
            rsp_o.kind = KindChrRam;
            rsp_o.bank = chr_val;
          end else begin
            rsp_o.kind = KindNametable;
            rsp_o.bank = {6'b000000, st_i.extra_vram & chr_val[1], chr_val[0]};
          end
        end
      end
      default: begin
        rsp_o.irq_line = st_i.irq;
      end
    endcase
  end

endmodule

FILE: rtl/cbm_state.sv
// ----------------------------------------------------------------------------
// cbm_state
// Bank, protect, counter and configuration registers with their update logic.
// ----------------------------------------------------------------------------
module cbm_state import cbm_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  cbm_cfg_if.sink cfg_i,
  input  logic  fire_i,
  input  upd_t  upd_i,
  output st_t   st_o
);

  st_t  st_q, st_d;
  logic cfg_fire;

  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid && cfg_i.ready;

  always_comb begin
    st_d = st_q;
    if (cfg_fire) begin
      case (cfg_i.index)
        CfgChrRam:    st_d.chr_ram    = cfg_i.data[0];
        CfgExtraVram: st_d.extra_vram = cfg_i.data[0];
        default:      st_d = st_q;
      endcase
    end
    if (fire_i) begin
      if (upd_i.chr_we)    st_d.chr[upd_i.chr_idx] = upd_i.data;
      if (upd_i.prg_we)    st_d.prg[upd_i.prg_idx] = upd_i.data;
      if (upd_i.prot_we)   st_d.prot               = upd_i.data;
      if (upd_i.ctr_lo_we) st_d.ctr[7:0]           = upd_i.data;
      if (upd_i.ctr_hi_we) st_d.ctr[15:8]          = upd_i.data;
      if (upd_i.ctr_inc)   st_d.ctr                = st_q.ctr + 16'd1;
      if (upd_i.irq_set)   st_d.irq                = 1'b1;
      if (upd_i.irq_clr)   st_d.irq                = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StRst;
    end else begin
      st_q <= st_d;
    end
  end

  assign st_o = st_q;

  a_irq_at_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.irq |-> (st_q.ctr == CtrTop))
    else $error("interrupt raised while counter is not at top");

  a_ctr_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire_i |=> $stable(st_q.ctr))
    else $error("counter moved without a request");

  a_irq_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && upd_i.irq_clr) |=> !st_q.irq)
    else $error("counter write did not clear the interrupt");

endmodule

FILE: rtl/cartridge_bank_mapper_with_irq_counter.sv
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_with_irq_counter
// Bank mapper with a 16-bit cycle counter interrupt.
// Path: an accepted request is held in the input register, decoded, and then
// registered in the response register; a waiting response can stall it.
// Throughput: one request per cycle while responses are accepted; the input
// and response registers let a new request enter while a response waits.
// Reset: banks to power-on values, protect 0xFF, counter and interrupt clear,
// configuration bits clear; no clearing pass.
// ----------------------------------------------------------------------------
module cartridge_bank_mapper_with_irq_counter import cbm_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  cbm_req_if.sink   req_i,
  cbm_rsp_if.source rsp_o,
  cbm_cfg_if.sink   cfg_i
);

  logic  s1_valid_q, s1_valid_d;
  item_t s1_item_q;
  logic  out_valid_q, out_valid_d;
  rsp_t  out_q;
  logic  req_fire;
  logic  advance;
  st_t   st;
  rsp_t  rsp;
  upd_t  upd;

  assign advance     = s1_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !s1_valid_q || advance;
  assign req_fire    = req_i.valid && req_i.ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (req_fire) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      s1_item_q <= '{op: req_i.operation, addr: req_i.address, wdata: req_i.write_data};
    end
    if (advance) begin
      out_q <= rsp;
    end
  end

  cbm_map u_map (
    .item_i (s1_item_q),
    .st_i   (st),
    .rsp_o  (rsp),
    .upd_o  (upd)
  );

  cbm_state u_state (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .fire_i (advance),
    .upd_i  (upd),
    .st_o   (st)
  );

  assign rsp_o.valid             = out_valid_q;
  assign rsp_o.read_data         = out_q.read_data;
  assign rsp_o.read_handled      = out_q.read_handled;
  assign rsp_o.irq_line          = out_q.irq_line;
  assign rsp_o.work_ram_write_ok = out_q.wram_ok;
  assign rsp_o.target_kind       = out_q.kind;
  assign rsp_o.target_bank       = out_q.bank;
  assign rsp_o.target_offset     = out_q.offset;

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_i.ready |-> (s1_valid_q && out_valid_q))
    else $error("request stalled with a free stage");

  a_advance_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("advanced request lost before response");

  a_irq_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (out_q.irq_line == st.irq))
    else $error("response interrupt differs from state");

endmodule
